[rtl/tgi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared widths, latencies, register codes and helpers for the trilinear
// grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

    localparam int IDX_W      = 12;
    localparam int EXT_W      = 13;
    localparam int SAMPLE_W   = 32;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = FRAC_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CORNERS    = 8;

    localparam logic [EXT_W-1:0] MAX_EXTENT = EXT_W'(4096);
    localparam logic [WGT_W-1:0] WGT_ONE    = WGT_W'(1) << FRAC_W;

    localparam int GRID_STAGES = (IDX_W + 1) / 2;
    localparam int FRAC_STAGES = (WGT_W + 1) / 2;
    localparam int AXIS_LAT    = GRID_STAGES + 1 + FRAC_STAGES;
    localparam int LERP_LAT    = 3;
    localparam int PIPE_LAT    = AXIS_LAT + 3 * LERP_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_SPACING   = 3'd0,
        REG_SAMPLE_SPACING = 3'd1,
        REG_LINE_COUNT     = 3'd2,
        REG_TRACE_COUNT    = 3'd3,
        REG_SAMPLE_COUNT   = 3'd4,
        REG_NULL_CODE      = 3'd5
    } t_cfg_reg;

    typedef enum int {
        C000 = 0, C100 = 1, C010 = 2, C110 = 3,
        C001 = 4, C101 = 5, C011 = 6, C111 = 7
    } t_corner;

    typedef struct packed {
        logic [EXT_W-1:0] spacing;
        logic [IDX_W-1:0] last;
    } t_axis_cfg;

    typedef struct packed {
        logic [WGT_W-1:0] weight;
        logic             on_grid;
    } t_axis_res;

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = EXT_W'(1);
        end else if (v > MAX_EXTENT) begin
            r = MAX_EXTENT;
        end
        return r;
    endfunction

endpackage

[rtl/tgi_pt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_pt_if
// Target point channel: indices and the eight corner samples.
// ----------------------------------------------------------------------------
interface tgi_pt_if;
    logic                                valid;
    logic                                ready;
    logic        [tgi_pkg::IDX_W-1:0]    line_index;
    logic        [tgi_pkg::IDX_W-1:0]    trace_index;
    logic        [tgi_pkg::IDX_W-1:0]    sample_index;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_000;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_100;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_010;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_110;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_001;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_101;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_011;
    logic signed [tgi_pkg::SAMPLE_W-1:0] corner_111;

    modport source (
        output valid, line_index, trace_index, sample_index,
               corner_000, corner_100, corner_010, corner_110,
               corner_001, corner_101, corner_011, corner_111,
        input  ready
    );
    modport sink (
        input  valid, line_index, trace_index, sample_index,
               corner_000, corner_100, corner_010, corner_110,
               corner_001, corner_101, corner_011, corner_111,
        output ready
    );
endinterface

[rtl/tgi_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_res_if
// Result channel: interpolated value and write flag.
// ----------------------------------------------------------------------------
interface tgi_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [tgi_pkg::SAMPLE_W-1:0] interpolated_value;
    logic                                write_enable;

    modport source (output valid, interpolated_value, write_enable, input ready);
    modport sink (input valid, interpolated_value, write_enable, output ready);
endinterface

[rtl/tgi_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tgi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tgi_pkg::CFG_IDX_W-1:0]     index;
    logic [tgi_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/tgi_axis_weight.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_axis_weight
// Pipelined near-corner weight along one axis: grid remainder by restoring
// division, cell setup, then the fraction quotient, two bits per stage.
// ----------------------------------------------------------------------------
module tgi_axis_weight (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  tgi_pkg::t_axis_cfg                 i_cfg,
    input  logic [tgi_pkg::IDX_W-1:0]          i_index,
    output tgi_pkg::t_axis_res                 o_res
);
    localparam int IW = tgi_pkg::IDX_W;
    localparam int EW = tgi_pkg::EXT_W;
    localparam int WW = tgi_pkg::WGT_W;
    localparam int GS = tgi_pkg::GRID_STAGES;
    localparam int FS = tgi_pkg::FRAC_STAGES;

    // grid remainder stages
    logic [IW-1:0] w_g_idx [GS];
    logic [IW-1:0] w_g_rem [GS];
    logic [IW-1:0] n_g_rem [GS];
    logic [IW-1:0] r_g_idx [GS];
    logic [IW-1:0] r_g_rem [GS];

    assign w_g_idx[0] = i_index;
    assign w_g_rem[0] = '0;

    for (genvar s = 0; s < GS; s++) begin : g_grid
        if (s > 0) begin : g_link
            assign w_g_idx[s] = r_g_idx[s-1];
            assign w_g_rem[s] = r_g_rem[s-1];
        end

        always_comb begin
            logic [EW-1:0] t;
            logic [IW-1:0] rem;
            rem = w_g_rem[s];
            for (int j = 0; j < 2; j++) begin
                if (s * 2 + j < IW) begin
                    t = {rem, w_g_idx[s][IW-1-(s*2+j)]};
                    if (t >= i_cfg.spacing) begin
                        t = t - i_cfg.spacing;
                    end
                    rem = t[IW-1:0];
                end
            end
            n_g_rem[s] = rem;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_g_idx[s] <= w_g_idx[s];
                r_g_rem[s] <= n_g_rem[s];
            end
        end
    end

    // cell setup
    logic [IW-1:0]   w_idx;
    logic [IW-1:0]   w_near;
    logic [IW+1:0]   w_far_raw;
    logic [IW-1:0]   w_far;
    logic [IW-1:0]   n_dist;
    logic [IW-1:0]   n_span;
    logic            n_full;
    logic [IW-1:0]   r_s_dist;
    logic [IW-1:0]   r_s_span;
    logic            r_s_full;
    logic            r_s_grid;

    assign w_idx     = r_g_idx[GS-1];
    assign w_near    = w_idx - r_g_rem[GS-1];
    assign w_far_raw = {2'b00, w_near} + (IW+2)'(i_cfg.spacing);
    assign w_far     = (w_far_raw > {2'b00, i_cfg.last}) ? i_cfg.last : w_far_raw[IW-1:0];
    assign n_full    = (w_far <= w_near);
    assign n_dist    = (w_far > w_idx) ? (w_far - w_idx) : '0;
    assign n_span    = w_far - w_near;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_dist <= n_dist;
            r_s_span <= n_span;
            r_s_full <= n_full;
            r_s_grid <= (r_g_rem[GS-1] == '0);
        end
    end

    // fraction quotient stages
    logic [IW-1:0] w_q_rem  [FS];
    logic [WW-1:0] w_q_quo  [FS];
    logic [IW-1:0] w_q_span [FS];
    logic          w_q_full [FS];
    logic          w_q_grid [FS];
    logic [IW-1:0] n_q_rem  [FS];
    logic [WW-1:0] n_q_quo  [FS];
    logic [IW-1:0] r_q_rem  [FS];
    logic [WW-1:0] r_q_quo  [FS];
    logic [IW-1:0] r_q_span [FS];
    logic          r_q_full [FS];
    logic          r_q_grid [FS];

    assign w_q_rem[0]  = r_s_dist;
    assign w_q_quo[0]  = '0;
    assign w_q_span[0] = r_s_span;
    assign w_q_full[0] = r_s_full;
    assign w_q_grid[0] = r_s_grid;

    for (genvar s = 0; s < FS; s++) begin : g_frac
        if (s > 0) begin : g_link
            assign w_q_rem[s]  = r_q_rem[s-1];
            assign w_q_quo[s]  = r_q_quo[s-1];
            assign w_q_span[s] = r_q_span[s-1];
            assign w_q_full[s] = r_q_full[s-1];
            assign w_q_grid[s] = r_q_grid[s-1];
        end

        always_comb begin
            logic [IW:0]   t;
            logic [IW-1:0] rem;
            logic [WW-1:0] quo;
            rem = w_q_rem[s];
            quo = w_q_quo[s];
            for (int j = 0; j < 2; j++) begin
                if (s * 2 + j < WW) begin
                    t = (s * 2 + j == 0) ? {1'b0, rem} : {rem, 1'b0};
                    if (t >= {1'b0, w_q_span[s]}) begin
                        t = t - {1'b0, w_q_span[s]};
                        quo[WW-1-(s*2+j)] = 1'b1;
                    end
                    rem = t[IW-1:0];
                end
            end
            n_q_rem[s] = rem;
            n_q_quo[s] = quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q_rem[s]  <= n_q_rem[s];
                r_q_quo[s]  <= n_q_quo[s];
                r_q_span[s] <= w_q_span[s];
                r_q_full[s] <= w_q_full[s];
                r_q_grid[s] <= w_q_grid[s];
            end
        end
    end

    // zero span gives the near corner full weight
    assign o_res.weight  = r_q_full[FS-1] ? tgi_pkg::WGT_ONE : r_q_quo[FS-1];
    assign o_res.on_grid = r_q_grid[FS-1];

endmodule

[rtl/tgi_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgi_lerp
// Three-stage linear blend: difference, weight product, rounded sum.
// ----------------------------------------------------------------------------
module tgi_lerp (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tgi_pkg::SAMPLE_W-1:0] i_near,
    input  logic signed [tgi_pkg::SAMPLE_W-1:0] i_far,
    input  logic        [tgi_pkg::WGT_W-1:0]    i_weight,
    output logic signed [tgi_pkg::SAMPLE_W-1:0] o_value
);
    localparam int SW = tgi_pkg::SAMPLE_W;
    localparam int DW = SW + 1;
    localparam int PW = DW + tgi_pkg::WGT_W + 1;
    localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (tgi_pkg::FRAC_W - 1);

    logic signed [DW-1:0] n_diff;
    logic signed [DW-1:0] r_diff;
    logic signed [SW-1:0] r_far1;
    logic [tgi_pkg::WGT_W-1:0] r_wgt;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] r_prod;
    logic signed [SW-1:0] r_far2;
    logic signed [PW-1:0] w_shift;
    logic signed [SW-1:0] n_value;
    logic signed [SW-1:0] r_value;

    assign n_diff  = DW'(i_near) - DW'(i_far);
    assign n_prod  = PW'(r_diff) * PW'($signed({1'b0, r_wgt}));
    assign w_shift = (r_prod + ROUND) >>> tgi_pkg::FRAC_W;
    assign n_value = r_far2 + w_shift[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff  <= n_diff;
            r_far1  <= i_far;
            r_wgt   <= i_weight;
            r_prod  <= n_prod;
            r_far2  <= r_far1;
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

[rtl/trilinear_grid_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_top
// Trilinear interpolation of one target point from its eight cell corners.
// ----------------------------------------------------------------------------
// i_pt carries a target point (line, trace, sample index) with its eight
// corner samples; o_res returns one value and write flag per point, in order.
// i_cfg writes the spacing, volume size and null code registers; it is always
// ready and should only be written while no point is in flight.
// From transfer in to result valid, a point passes the per-axis weight
// dividers (grid remainder then fraction quotient, two bits a stage) and
// then the three blend levels. Throughput is one point per cycle.
// The whole pipeline advances together; when o_res is stalled with a result
// waiting, i_pt.ready drops and every stage holds.
// Reset clears the valid bits and loads the register defaults (spacing 4,
// sizes 4096, null code the most negative sample).
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tgi_pt_if.sink    i_pt,
    tgi_res_if.source o_res,
    tgi_cfg_if.sink   i_cfg
);
    localparam int SW = tgi_pkg::SAMPLE_W;
    localparam int EW = tgi_pkg::EXT_W;
    localparam int AL = tgi_pkg::AXIS_LAT;
    localparam int LL = tgi_pkg::LERP_LAT;
    localparam int PL = tgi_pkg::PIPE_LAT;
    localparam int NC = tgi_pkg::CORNERS;

    // configuration
    logic [EW-1:0]        r_line_spacing;
    logic [EW-1:0]        r_sample_spacing;
    logic [EW-1:0]        r_line_count;
    logic [EW-1:0]        r_trace_count;
    logic [EW-1:0]        r_sample_count;
    logic signed [SW-1:0] r_null_code;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_spacing   <= EW'(4);
            r_sample_spacing <= EW'(4);
            r_line_count     <= tgi_pkg::MAX_EXTENT;
            r_trace_count    <= tgi_pkg::MAX_EXTENT;
            r_sample_count   <= tgi_pkg::MAX_EXTENT;
            r_null_code      <= {1'b1, {(SW-1){1'b0}}};
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (tgi_pkg::t_cfg_reg'(i_cfg.index))
                tgi_pkg::REG_LINE_SPACING:   r_line_spacing   <= i_cfg.data[EW-1:0];
                tgi_pkg::REG_SAMPLE_SPACING: r_sample_spacing <= i_cfg.data[EW-1:0];
                tgi_pkg::REG_LINE_COUNT:     r_line_count     <= i_cfg.data[EW-1:0];
                tgi_pkg::REG_TRACE_COUNT:    r_trace_count    <= i_cfg.data[EW-1:0];
                tgi_pkg::REG_SAMPLE_COUNT:   r_sample_count   <= i_cfg.data[EW-1:0];
                tgi_pkg::REG_NULL_CODE:      r_null_code      <= $signed(i_cfg.data[SW-1:0]);
                default: begin
                end
            endcase
        end
    end

    tgi_pkg::t_axis_cfg w_cfg_l;
    tgi_pkg::t_axis_cfg w_cfg_t;
    tgi_pkg::t_axis_cfg w_cfg_s;

    assign w_cfg_l.spacing = tgi_pkg::clamp_ext(r_line_spacing);
    assign w_cfg_l.last    = tgi_pkg::IDX_W'(tgi_pkg::clamp_ext(r_line_count) - EW'(1));
    assign w_cfg_t.spacing = tgi_pkg::clamp_ext(r_line_spacing);
    assign w_cfg_t.last    = tgi_pkg::IDX_W'(tgi_pkg::clamp_ext(r_trace_count) - EW'(1));
    assign w_cfg_s.spacing = tgi_pkg::clamp_ext(r_sample_spacing);
    assign w_cfg_s.last    = tgi_pkg::IDX_W'(tgi_pkg::clamp_ext(r_sample_count) - EW'(1));

    // pipeline control
    logic          w_en;
    logic [PL-1:0] r_vld;

    assign w_en       = !r_vld[PL-1] || o_res.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PL-2:0], i_pt.valid};
        end
    end

    // axis weights
    tgi_pkg::t_axis_res w_wl;
    tgi_pkg::t_axis_res w_wt;
    tgi_pkg::t_axis_res w_ws;

    tgi_axis_weight u_axis_l (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(w_cfg_l),
        .i_index(i_pt.line_index), .o_res(w_wl)
    );
    tgi_axis_weight u_axis_t (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(w_cfg_t),
        .i_index(i_pt.trace_index), .o_res(w_wt)
    );
    tgi_axis_weight u_axis_s (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(w_cfg_s),
        .i_index(i_pt.sample_index), .o_res(w_ws)
    );

    // corner delay line
    logic signed [SW-1:0] w_cor_in [NC];
    logic signed [SW-1:0] r_cor [AL][NC];

    assign w_cor_in[tgi_pkg::C000] = i_pt.corner_000;
    assign w_cor_in[tgi_pkg::C100] = i_pt.corner_100;
    assign w_cor_in[tgi_pkg::C010] = i_pt.corner_010;
    assign w_cor_in[tgi_pkg::C110] = i_pt.corner_110;
    assign w_cor_in[tgi_pkg::C001] = i_pt.corner_001;
    assign w_cor_in[tgi_pkg::C101] = i_pt.corner_101;
    assign w_cor_in[tgi_pkg::C011] = i_pt.corner_011;
    assign w_cor_in[tgi_pkg::C111] = i_pt.corner_111;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cor[0] <= w_cor_in;
            for (int s = 1; s < AL; s++) begin
                r_cor[s] <= r_cor[s-1];
            end
        end
    end

    // write flag and weight alignment
    logic                           n_we;
    logic [3*LL-1:0]                r_we;
    logic [tgi_pkg::WGT_W-1:0]      r_fj [LL];
    logic [tgi_pkg::WGT_W-1:0]      r_fk [2*LL];

    always_comb begin
        logic any_null;
        any_null = 1'b0;
        for (int n = 0; n < NC; n++) begin
            if (r_cor[AL-1][n] == r_null_code) begin
                any_null = 1'b1;
            end
        end
        n_we = !(w_wl.on_grid && w_wt.on_grid && w_ws.on_grid) && !any_null;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_we    <= {r_we[3*LL-2:0], n_we};
            r_fj[0] <= w_wt.weight;
            r_fk[0] <= w_ws.weight;
            for (int s = 1; s < LL; s++) begin
                r_fj[s] <= r_fj[s-1];
            end
            for (int s = 1; s < 2 * LL; s++) begin
                r_fk[s] <= r_fk[s-1];
            end
        end
    end

    // blend tree: lines, then traces, then samples
    logic signed [SW-1:0] w_a00, w_a10, w_a01, w_a11, w_b0, w_b1, w_r;

    tgi_lerp u_a00 (.i_clk(i_clk), .i_en(w_en), .i_near(r_cor[AL-1][tgi_pkg::C000]),
        .i_far(r_cor[AL-1][tgi_pkg::C100]), .i_weight(w_wl.weight), .o_value(w_a00));
    tgi_lerp u_a10 (.i_clk(i_clk), .i_en(w_en), .i_near(r_cor[AL-1][tgi_pkg::C010]),
        .i_far(r_cor[AL-1][tgi_pkg::C110]), .i_weight(w_wl.weight), .o_value(w_a10));
    tgi_lerp u_a01 (.i_clk(i_clk), .i_en(w_en), .i_near(r_cor[AL-1][tgi_pkg::C001]),
        .i_far(r_cor[AL-1][tgi_pkg::C101]), .i_weight(w_wl.weight), .o_value(w_a01));
    tgi_lerp u_a11 (.i_clk(i_clk), .i_en(w_en), .i_near(r_cor[AL-1][tgi_pkg::C011]),
        .i_far(r_cor[AL-1][tgi_pkg::C111]), .i_weight(w_wl.weight), .o_value(w_a11));
    tgi_lerp u_b0 (.i_clk(i_clk), .i_en(w_en), .i_near(w_a00), .i_far(w_a10),
        .i_weight(r_fj[LL-1]), .o_value(w_b0));
    tgi_lerp u_b1 (.i_clk(i_clk), .i_en(w_en), .i_near(w_a01), .i_far(w_a11),
        .i_weight(r_fj[LL-1]), .o_value(w_b1));
    tgi_lerp u_r (.i_clk(i_clk), .i_en(w_en), .i_near(w_b0), .i_far(w_b1),
        .i_weight(r_fk[2*LL-1]), .o_value(w_r));

    assign o_res.valid              = r_vld[PL-1];
    assign o_res.write_enable       = r_we[3*LL-1];
    assign o_res.interpolated_value = r_we[3*LL-1] ? w_r : '0;

    // checks
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && i_pt.valid |=> r_vld[0])
        else $error("accepted point lost at pipeline entry");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[AL-1] |-> (w_wl.weight <= tgi_pkg::WGT_ONE) &&
                        (w_wt.weight <= tgi_pkg::WGT_ONE) &&
                        (w_ws.weight <= tgi_pkg::WGT_ONE))
        else $error("axis weight above unity");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trilinear grid interpolator: drives points with
// random idling and a long output hold-off, predicts each result in fixed
// point and compares it in order against the block's output.
// ----------------------------------------------------------------------------
class interp_scoreboard;
    logic [12:0] spacing_l, spacing_s, count_l, count_t, count_s;
    logic signed [31:0] null_val;
    logic signed [31:0] want_value[$];
    logic want_we[$];
    int errors;

    function new();
        spacing_l = 4; spacing_s = 4;
        count_l = 4096; count_t = 4096; count_s = 4096;
        null_val = 32'sh80000000;
        errors = 0;
    endfunction

    function longint clamp(logic [12:0] v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function longint weight(longint idx, logic [12:0] spc, logic [12:0] cnt);
        longint sp, last, nr, fr, gap;
        sp = clamp(spc);
        last = clamp(cnt) - 1;
        nr = (idx / sp) * sp;
        fr = nr + sp;
        if (fr > last) fr = last;
        if (fr <= nr) return 65536;
        gap = (fr > idx) ? fr - idx : 0;
        return (gap << 16) / (fr - nr);
    endfunction

    function longint blend(longint nv, longint fv, longint f);
        longint d, dl, dh, lowpart;
        d = nv - fv;
        dl = d & 65535;
        dh = (d - dl) / 65536;
        lowpart = (dl * f + 32768) >>> 16;
        return fv + dh * f + lowpart;
    endfunction

    function void note_point(logic [11:0] li, logic [11:0] ti, logic [11:0] si,
                             logic signed [31:0] c[8]);
        longint fi, fj, fk, a00, a10, a01, a11, b0, b1;
        bit skip;
        skip = (li % clamp(spacing_l) == 0) && (ti % clamp(spacing_l) == 0) &&
               (si % clamp(spacing_s) == 0);
        foreach (c[n]) if (c[n] == null_val) skip = 1;
        if (skip) begin
            want_value.push_back(0);
            want_we.push_back(0);
            return;
        end
        fi = weight(li, spacing_l, count_l);
        fj = weight(ti, spacing_l, count_t);
        fk = weight(si, spacing_s, count_s);
        a00 = blend(c[0], c[1], fi);
        a10 = blend(c[2], c[3], fi);
        a01 = blend(c[4], c[5], fi);
        a11 = blend(c[6], c[7], fi);
        b0 = blend(a00, a10, fj);
        b1 = blend(a01, a11, fj);
        want_value.push_back(32'(blend(b0, b1, fk)));
        want_we.push_back(1);
    endfunction

    function void check_result(logic signed [31:0] v, logic we);
        logic signed [31:0] ev;
        logic ew;
        if (want_value.size() == 0) begin
            $error("unexpected result value %0d", v);
            errors++;
            return;
        end
        ev = want_value.pop_front();
        ew = want_we.pop_front();
        if (we !== ew) begin
            $error("write_enable expected %0d actual %0d", ew, we);
            errors++;
        end
        if (v !== ev) begin
            $error("interpolated_value expected %0d actual %0d", ev, v);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic i_clk = 0;
    logic i_rst_n = 0;
    tgi_pt_if  pt_bus();
    tgi_res_if res_bus();
    tgi_cfg_if cfg_bus();

    trilinear_grid_interpolator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pt(pt_bus.sink), .o_res(res_bus.source), .i_cfg(cfg_bus.sink)
    );

    interp_scoreboard board = new();
    int send_gap = 12, recv_gap = 52;
    int hold_cycles = 0;
    int quiet = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        pt_bus.valid = 0;
        pt_bus.line_index = 0; pt_bus.trace_index = 0; pt_bus.sample_index = 0;
        pt_bus.corner_000 = 0; pt_bus.corner_100 = 0; pt_bus.corner_010 = 0;
        pt_bus.corner_110 = 0; pt_bus.corner_001 = 0; pt_bus.corner_101 = 0;
        pt_bus.corner_011 = 0; pt_bus.corner_111 = 0;
        res_bus.ready = 0;
        cfg_bus.valid = 0; cfg_bus.index = 0; cfg_bus.data = 0;
    end

    // sink side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            board.check_result(res_bus.interpolated_value, res_bus.write_enable);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_bus.ready <= 0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= recv_gap);
        end
    end

    always @(posedge i_clk) begin
        if ((pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic write_reg(tgi_pkg::t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 0;
        case (idx)
            tgi_pkg::REG_LINE_SPACING:   board.spacing_l = val[12:0];
            tgi_pkg::REG_SAMPLE_SPACING: board.spacing_s = val[12:0];
            tgi_pkg::REG_LINE_COUNT:     board.count_l = val[12:0];
            tgi_pkg::REG_TRACE_COUNT:    board.count_t = val[12:0];
            tgi_pkg::REG_SAMPLE_COUNT:   board.count_s = val[12:0];
            tgi_pkg::REG_NULL_CODE:      board.null_val = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (board.want_value.size() != 0) @(posedge i_clk);
        repeat (tgi_pkg::PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic send_point(logic [11:0] li, logic [11:0] ti, logic [11:0] si,
                              logic signed [31:0] c[8]);
        while ($urandom_range(99) < send_gap) begin
            pt_bus.valid <= 0;
            @(posedge i_clk);
        end
        pt_bus.valid <= 1;
        pt_bus.line_index <= li; pt_bus.trace_index <= ti; pt_bus.sample_index <= si;
        pt_bus.corner_000 <= c[tgi_pkg::C000]; pt_bus.corner_100 <= c[tgi_pkg::C100];
        pt_bus.corner_010 <= c[tgi_pkg::C010]; pt_bus.corner_110 <= c[tgi_pkg::C110];
        pt_bus.corner_001 <= c[tgi_pkg::C001]; pt_bus.corner_101 <= c[tgi_pkg::C101];
        pt_bus.corner_011 <= c[tgi_pkg::C011]; pt_bus.corner_111 <= c[tgi_pkg::C111];
        do @(posedge i_clk); while (!pt_bus.ready);
        board.note_point(li, ti, si, c);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000001;
            2: return $signed(32'($urandom_range(2000))) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(int num);
        logic signed [31:0] c[8];
        logic [11:0] li, ti, si;
        for (int k = 0; k < num; k++) begin
            foreach (c[n]) c[n] = rand_sample();
            if ($urandom_range(19) == 0) c[$urandom_range(7)] = board.null_val;
            li = 12'($urandom); ti = 12'($urandom); si = 12'($urandom);
            if ($urandom_range(9) == 0) begin
                li = 12'd4095; ti = 12'd4095; si = 12'd4095;
            end
            send_point(li, ti, si, c);
        end
        pt_bus.valid <= 0;
    endtask

    task automatic config_set(int ls, int ss, int lc, int tc, int sc, logic [31:0] nc);
        wait_drained();
        write_reg(tgi_pkg::REG_LINE_SPACING, ls);
        write_reg(tgi_pkg::REG_SAMPLE_SPACING, ss);
        write_reg(tgi_pkg::REG_LINE_COUNT, lc);
        write_reg(tgi_pkg::REG_TRACE_COUNT, tc);
        write_reg(tgi_pkg::REG_SAMPLE_COUNT, sc);
        write_reg(tgi_pkg::REG_NULL_CODE, nc);
    endtask

    initial begin
        logic signed [31:0] c[8];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: grid point, null corner, extremes, clipped far corner
        foreach (c[n]) c[n] = (n % 2) ? 32'sh7fffffff : 32'sh80000001;
        send_point(0, 0, 0, c);
        send_point(1, 2, 3, c);
        send_point(4095, 4095, 4095, c);
        send_point(4093, 4094, 4095, c);
        foreach (c[n]) c[n] = n * 1000 - 3000;
        send_point(2, 1, 3, c);
        c[tgi_pkg::C110] = 32'sh80000000;
        send_point(2, 1, 3, c);
        foreach (c[n]) c[n] = $urandom;
        send_point(12'hfff, 0, 12'h001, c);
        send_point(12'h555, 12'haaa, 12'h123, c);
        pt_bus.valid <= 0;

        // zero span, index beyond far, zero and oversize registers
        config_set(4, 3, 10, 1, 4096, 32'h0);
        foreach (c[n]) c[n] = n + 1;
        send_point(9, 0, 5, c);
        send_point(100, 3000, 4094, c);
        send_point(8, 2, 1, c);
        c[tgi_pkg::C000] = 0;
        send_point(1, 1, 1, c);
        pt_bus.valid <= 0;
        config_set(0, 8191, 0, 8191, 0, 32'h12345678);
        foreach (c[n]) c[n] = $urandom;
        send_point(0, 0, 7, c);
        send_point(1, 2, 4095, c);
        pt_bus.valid <= 0;

        send_gap = 12; recv_gap = 52;
        config_set(4, 4, 4096, 4096, 4096, 32'h80000000);
        random_points(150);
        config_set(4096, 4096, 4096, 4096, 4096, $urandom);
        random_points(150);
        send_gap = 52; recv_gap = 12;
        config_set(1, 1, 1, 1, 1, 32'h7fffffff);
        random_points(100);
        config_set($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 4096),
                   $urandom_range(1, 4096), $urandom_range(1, 4096), $urandom);
        random_points(200);
        send_gap = 0; recv_gap = 0;
        config_set($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(1, 200),
                   $urandom_range(1, 200), $urandom_range(1, 200), 32'h80000000);
        wait_drained();
        hold_cycles = 200;
        random_points(330);

        wait_drained();
        if (board.errors == 0 && board.want_value.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

[sim.f]
rtl/tgi_pkg.sv
rtl/tgi_pt_if.sv
rtl/tgi_res_if.sv
rtl/tgi_cfg_if.sv
rtl/tgi_axis_weight.sv
rtl/tgi_lerp.sv
rtl/trilinear_grid_interpolator_top.sv
test/tb_top.sv
